[design/posc_pkg.sv]
`timescale 1ns / 1ps
package posc_pkg;

	localparam int VOICE_COUNT = 16;
	localparam int PHASE_BITS = 24;
	localparam int SINE_TABLE_BITS = 10;

	localparam int STEP_IN_W = 24;
	localparam int VIDX_IN_W = 4;
	localparam int ACTIVE_W = 5;
	localparam int FUNC_W = 2;
	localparam int SINE_W = 16;
	localparam int OUT_W = 20;

	localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int CNT_W = $clog2(VOICE_COUNT + 1);
	localparam int SUM_W = OUT_W + 1 + $clog2(VOICE_COUNT);
	localparam int QUARTER = 2 ** (SINE_TABLE_BITS - 2);
	localparam int OUT_MAX = 2 ** (OUT_W - 1) - 1;
	localparam int OUT_MIN = -(2 ** (OUT_W - 1));
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned AMP = 64'd32767;

	// Series denominators (2n)(2n+1) for the ten correction terms.
	localparam longint unsigned TAYLOR_DIV [1:10] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
		64'd156, 64'd210, 64'd272, 64'd342, 64'd420
	};

	typedef enum logic [FUNC_W-1:0] {
		FN_LOAD  = 2'd0,
		FN_FRAME = 2'd1,
		FN_HALVE = 2'd2,
		FN_NONE  = 2'd3
	} func_t;

	typedef logic [SINE_W-2:0] qsine_t [0:QUARTER];

	// Quarter-wave sine built at elaboration from a truncated Q30 Taylor series.
	function automatic qsine_t build_qsine();
		qsine_t t;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned sum;
		longint unsigned v;
		for (int r = 0; r <= QUARTER; r++) begin
			x = (HALF_PI_Q30 * longint'(r)) >> (SINE_TABLE_BITS - 2);
			x2 = (x * x) >> 30;
			term = x;
			sum = x;
			for (int n = 1; n <= 10; n++) begin
				term = ((term * x2) >> 30) / TAYLOR_DIV[n];
				if (n[0]) begin
					sum = (sum >= term) ? sum - term : 64'd0;
				end else begin
					sum = sum + term;
				end
			end
			v = (sum * AMP + (64'd1 << 29)) >> 30;
			if (v > AMP) begin
				v = AMP;
			end
			t[r] = v[SINE_W-2:0];
		end
		return t;
	endfunction

	localparam qsine_t QSINE = build_qsine();

	// Rescales a Q0.24 step to the phase accumulator width.
	function automatic logic [PHASE_BITS-1:0] scale_step(input logic [STEP_IN_W-1:0] s);
		logic [STEP_IN_W+PHASE_BITS-1:0] wide;
		wide = {{PHASE_BITS{1'b0}}, s};
		if (PHASE_BITS >= STEP_IN_W) begin
			wide = wide << (PHASE_BITS - STEP_IN_W);
		end else begin
			wide = wide >> (STEP_IN_W - PHASE_BITS);
		end
		return wide[PHASE_BITS-1:0];
	endfunction

endpackage

[design/posc_sine.sv]
`timescale 1ns / 1ps
module posc_sine import posc_pkg::*; (
	input  logic [SINE_TABLE_BITS-1:0] idx,
	output logic signed [SINE_W-1:0]   sine
);

	logic [1:0]                 quad;
	logic [SINE_TABLE_BITS-3:0] r;
	logic [SINE_TABLE_BITS-2:0] addr;
	logic [SINE_W-2:0]          mag;

	assign quad = idx[SINE_TABLE_BITS-1 -: 2];
	assign r = idx[SINE_TABLE_BITS-3:0];

	// Odd quadrants read the quarter wave backwards; the lower half is negated.
	always_comb begin
		if (quad[0]) begin
			addr = (SINE_TABLE_BITS-1)'(QUARTER) - {1'b0, r};
		end else begin
			addr = {1'b0, r};
		end
		mag = QSINE[addr];
		if (quad[1]) begin
			sine = -$signed({1'b0, mag});
		end else begin
			sine = $signed({1'b0, mag});
		end
	end

endmodule

[design/posc_core.sv]
`timescale 1ns / 1ps
module posc_core import posc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [FUNC_W-1:0]         func,
	input  logic [VIDX_IN_W-1:0]      voice_index,
	input  logic [STEP_IN_W-1:0]      phase_step,
	input  logic [ACTIVE_W-1:0]       active_count,
	output logic [SINE_TABLE_BITS-1:0] lut_idx,
	input  logic signed [SINE_W-1:0]  lut_sine,
	output logic                      res_valid,
	input  logic                      res_take,
	output logic signed [OUT_W-1:0]   res_sample
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FRAME,
		ST_HALVE,
		ST_DONE
	} state_t;

	localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(OUT_MAX);
	localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(OUT_MIN);

	state_t                     state_q;
	logic [PHASE_BITS-1:0]      phase_q [VOICE_COUNT];
	logic [PHASE_BITS-1:0]      step_q [VOICE_COUNT];
	logic [CNT_W-1:0]           cnt_q;
	logic [CNT_W-1:0]           last_q;
	logic [SINE_TABLE_BITS-1:0] idx_s1;
	logic                       idx_vld_s1;
	logic signed [SUM_W-1:0]    sum_q;

	logic [CNT_W-1:0]      act;
	logic [PHASE_BITS-1:0] phase_new;
	logic [VIDX_W-1:0]     vsel;
	logic                  accept;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign lut_idx = idx_s1;
	assign vsel = cnt_q[VIDX_W-1:0];
	assign phase_new = phase_q[vsel] + step_q[vsel];

	always_comb begin
		if (32'(active_count) > VOICE_COUNT) begin
			act = CNT_W'(VOICE_COUNT);
		end else begin
			act = CNT_W'(active_count);
		end
	end

	always_comb begin
		if (sum_q > SUM_MAX) begin
			res_sample = OUT_W'(SUM_MAX);
		end else if (sum_q < SUM_MIN) begin
			res_sample = OUT_W'(SUM_MIN);
		end else begin
			res_sample = OUT_W'(sum_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			last_q <= '0;
			idx_s1 <= '0;
			idx_vld_s1 <= 1'b0;
			sum_q <= '0;
			for (int v = 0; v < VOICE_COUNT; v++) begin
				phase_q[v] <= '0;
				step_q[v] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (func_t'(func))
							FN_LOAD: begin
								if (32'(voice_index) < VOICE_COUNT) begin
									step_q[VIDX_W'(voice_index)] <= scale_step(phase_step);
								end
							end
							FN_FRAME: begin
								cnt_q <= '0;
								last_q <= act;
								sum_q <= '0;
								idx_vld_s1 <= 1'b0;
								state_q <= ST_FRAME;
							end
							FN_HALVE: begin
								cnt_q <= (act == CNT_W'(VOICE_COUNT)) ? '0 : act;
								state_q <= ST_HALVE;
							end
							default: begin
							end
						endcase
					end
				end
				ST_FRAME: begin
					// Phase update runs one voice ahead of the table add.
					if (idx_vld_s1) begin
						sum_q <= sum_q + SUM_W'(lut_sine);
					end
					if (cnt_q < last_q) begin
						phase_q[vsel] <= phase_new;
						idx_s1 <= phase_new[PHASE_BITS-1 -: SINE_TABLE_BITS];
						idx_vld_s1 <= 1'b1;
						cnt_q <= cnt_q + 1'b1;
					end else begin
						idx_vld_s1 <= 1'b0;
						if (!idx_vld_s1) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_HALVE: begin
					if (cnt_q < CNT_W'(VOICE_COUNT)) begin
						phase_q[vsel] <= phase_q[vsel] >> 1;
						cnt_q <= cnt_q + 1'b1;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[design/polyphonic_sine_oscillator_bank_unit.sv]
`timescale 1ns / 1ps
// Bank of 16 phase-accumulator sine oscillators mixed into one 20-bit sample.
// The item kind travels in s_tuser; n below is active_count capped at 16. A load
// item writes one voice step. A frame item steps n voices, one voice per cycle
// through a single phase adder and a 1024-point sine table, then adds the last
// sine, finishes and hands the sample to the output register; it yields one item
// on the master side. An end-of-buffer item halves the phase of each voice from n
// up, one voice per cycle (of every voice when all voices are active). The input
// stays not ready while an item is being worked on. A finished sample sits in an
// output register, so the next item can be taken while it waits; a second frame
// then holds its sample until that register frees.
module polyphonic_sine_oscillator_bank_unit import posc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // voice_index[3:0], phase_step[27:4], active_count[32:28], zero
	input  logic [1:0]  s_tuser,  // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // mixed_sample[19:0], zero
);

	logic [SINE_TABLE_BITS-1:0] lut_idx;
	logic signed [SINE_W-1:0]   lut_sine;
	logic                       res_valid;
	logic                       res_take;
	logic signed [OUT_W-1:0]    res_sample;
	logic                       m_tvalid_q;
	logic signed [OUT_W-1:0]    sample_q;

	assign res_take = res_valid && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {4'b0000, sample_q};

	posc_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.func         (s_tuser),
		.voice_index  (s_tdata[3:0]),
		.phase_step   (s_tdata[27:4]),
		.active_count (s_tdata[32:28]),
		.lut_idx      (lut_idx),
		.lut_sine     (lut_sine),
		.res_valid    (res_valid),
		.res_take     (res_take),
		.res_sample   (res_sample)
	);

	posc_sine u_sine (
		.idx  (lut_idx),
		.sine (lut_sine)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			sample_q <= '0;
		end else begin
			if (res_take) begin
				m_tvalid_q <= 1'b1;
				sample_q <= res_sample;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench import posc_pkg::*;;

	localparam int CYCLE_LIMIT = 600000;
	localparam int ITEMS_PER_PHASE = 617;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		func_t       func;
		logic [3:0]  voice;
		logic [23:0] step;
		logic [4:0]  count;
		bit          typed;
		logic [19:0] sample;
	} osc_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;

	logic [PHASE_BITS-1:0] voice_phase [VOICE_COUNT];
	logic [PHASE_BITS-1:0] voice_step [VOICE_COUNT];
	int                    sine_lut [2 ** SINE_TABLE_BITS];
	logic [19:0]           pending_mix [$];
	logic [19:0]           wanted_mix;

	int error_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_left = 0;
	bit hold_request = 1'b0;

	// The first rows have results that follow directly from reset and a quarter-cycle step.
	osc_item_t directed_rows [24] = '{
		'{FN_FRAME, 4'd0,  24'h000000, 5'd16, 1'b1, 20'sd0},
		'{FN_FRAME, 4'd0,  24'h000000, 5'd0,  1'b1, 20'sd0},
		'{FN_LOAD,  4'd0,  24'h400000, 5'd0,  1'b0, 20'd0},
		'{FN_FRAME, 4'd0,  24'h000000, 5'd1,  1'b1, 20'sd32767},
		'{FN_FRAME, 4'd0,  24'h000000, 5'd1,  1'b1, 20'sd0},
		'{FN_FRAME, 4'd0,  24'h000000, 5'd1,  1'b1, -20'sd32767},
		'{FN_LOAD,  4'd15, 24'hFFFFFF, 5'd0,  1'b0, 20'd0},
		'{FN_LOAD,  4'd7,  24'h000001, 5'd31, 1'b0, 20'd0},
		'{FN_LOAD,  4'd9,  24'hA5A5A5, 5'd0,  1'b0, 20'd0},
		'{FN_FRAME, 4'd0,  24'h000000, 5'd16, 1'b0, 20'd0},
		'{FN_FRAME, 4'd15, 24'hFFFFFF, 5'd31, 1'b0, 20'd0},
		'{FN_HALVE, 4'd0,  24'h000000, 5'd16, 1'b0, 20'd0},
		'{FN_FRAME, 4'd0,  24'h000000, 5'd16, 1'b0, 20'd0},
		'{FN_HALVE, 4'd0,  24'h000000, 5'd31, 1'b0, 20'd0},
		'{FN_HALVE, 4'd0,  24'h000000, 5'd0,  1'b0, 20'd0},
		'{FN_HALVE, 4'd0,  24'h000000, 5'd8,  1'b0, 20'd0},
		'{FN_FRAME, 4'd0,  24'h000000, 5'd8,  1'b0, 20'd0},
		'{FN_NONE,  4'd15, 24'hFFFFFF, 5'd31, 1'b0, 20'd0},
		'{FN_LOAD,  4'd3,  24'hAAAAAA, 5'd0,  1'b0, 20'd0},
		'{FN_LOAD,  4'd12, 24'h555555, 5'd0,  1'b0, 20'd0},
		'{FN_FRAME, 4'd0,  24'h000000, 5'd15, 1'b0, 20'd0},
		'{FN_FRAME, 4'd0,  24'h000000, 5'd17, 1'b0, 20'd0},
		'{FN_HALVE, 4'd0,  24'h000000, 5'd15, 1'b0, 20'd0},
		'{FN_FRAME, 4'd0,  24'h000000, 5'd16, 1'b0, 20'd0}
	};

	polyphonic_sine_oscillator_bank_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// Quarter-wave sine, Q30 Taylor series with truncated terms, scaled to 32767.
	function automatic int quarter_wave(input int r);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned acc;
		longint unsigned v;
		x = (HALF_PI_Q30 * longint'(r)) / longint'(QUARTER);
		x2 = (x * x) >> 30;
		term = x;
		acc = x;
		for (int n = 1; n <= 10; n++) begin
			term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = (acc >= term) ? acc - term : 64'd0;
			end else begin
				acc = acc + term;
			end
		end
		v = (acc * AMP + (64'd1 << 29)) >> 30;
		if (v > AMP) begin
			v = AMP;
		end
		return int'(v);
	endfunction

	// Applies one accepted item to the voice bank; returns 1 when it yields a sample.
	function automatic bit bank_update(input osc_item_t it, output logic [19:0] sample);
		int used;
		int acc;
		int first;
		used = (it.count > VOICE_COUNT) ? VOICE_COUNT : int'(it.count);
		acc = 0;
		sample = '0;
		case (it.func)
			FN_LOAD: begin
				voice_step[it.voice] = it.step;
			end
			FN_FRAME: begin
				for (int v = 0; v < used; v++) begin
					voice_phase[v] = voice_phase[v] + voice_step[v];
					acc += sine_lut[voice_phase[v] >> (PHASE_BITS - SINE_TABLE_BITS)];
				end
				if (acc > OUT_MAX) begin
					acc = OUT_MAX;
				end
				if (acc < OUT_MIN) begin
					acc = OUT_MIN;
				end
				sample = acc[19:0];
				return 1'b1;
			end
			FN_HALVE: begin
				first = (used >= VOICE_COUNT) ? 0 : used;
				for (int v = first; v < VOICE_COUNT; v++) begin
					voice_phase[v] = voice_phase[v] >> 1;
				end
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string what);
		error_count++;
		$display("[%0t] MISMATCH: %s", $realtime, what);
	endtask

	task automatic offer_item(input osc_item_t it);
		logic [19:0] predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.func;
		s_tdata <= {7'd0, it.count, it.step, it.voice};
		do @(posedge clk); while (!s_tready);
		if (bank_update(it, predicted)) begin
			pending_mix.push_back(it.typed ? it.sample : predicted);
		end
	endtask

	function automatic logic [23:0] pick_step();
		case ($urandom_range(9))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			2: return 24'($urandom_range(255));
			default: return 24'($urandom());
		endcase
	endfunction

	function automatic logic [4:0] pick_count();
		return ($urandom_range(7) == 0) ? 5'($urandom_range(31, 17)) : 5'($urandom_range(16));
	endfunction

	function automatic osc_item_t random_item();
		osc_item_t it;
		int pick;
		it = '0;
		it.voice = 4'($urandom());
		it.step = pick_step();
		it.count = pick_count();
		pick = $urandom_range(99);
		if (pick < 30) begin
			it.func = FN_LOAD;
		end else if (pick < 75) begin
			it.func = FN_FRAME;
		end else if (pick < 94) begin
			it.func = FN_HALVE;
		end else begin
			it.func = FN_NONE;
			it.count = 5'($urandom());
		end
		return it;
	endfunction

	// Clears every phase by repeated halving, tunes all voices alike and plays
	// full-bank frames, which drives the mix to its extremes.
	task automatic play_chord(input logic [23:0] step, inout int sent);
		osc_item_t it;
		it = '0;
		it.func = FN_HALVE;
		for (int k = 0; k < PHASE_BITS; k++) begin
			it.count = ($urandom_range(1) == 0) ? 5'd0 : 5'($urandom_range(31, 16));
			offer_item(it);
		end
		it.func = FN_LOAD;
		it.step = step;
		for (int v = 0; v < VOICE_COUNT; v++) begin
			it.voice = 4'(v);
			offer_item(it);
		end
		it.func = FN_FRAME;
		it.count = 5'd16;
		for (int k = 0; k < 4; k++) begin
			offer_item(it);
		end
		sent += PHASE_BITS + VOICE_COUNT + 4;
	endtask

	initial begin
		osc_item_t it;
		int sent;
		int q;
		for (int i = 0; i < 2 ** SINE_TABLE_BITS; i++) begin
			q = (i / QUARTER) % 4;
			sine_lut[i] = (q == 0 || q == 2) ? quarter_wave(i % QUARTER)
				: quarter_wave(QUARTER - i % QUARTER);
			if (q >= 2) begin
				sine_lut[i] = -sine_lut[i];
			end
		end
		for (int v = 0; v < VOICE_COUNT; v++) begin
			voice_phase[v] = '0;
			voice_step[v] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			offer_item(directed_rows[i]);
		end

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 85 : 0;
			recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 33 : 0;
			// With the output blocked for a long stretch, the bank must stall its input.
			if (phase == 2) begin
				hold_request = 1'b1;
			end
			sent = 0;
			play_chord((phase == 1) ? 24'hC00000 : 24'h400000, sent);
			while (sent < ITEMS_PER_PHASE) begin
				if ($urandom_range(49) == 0) begin
					play_chord(pick_step(), sent);
				end else begin
					it = random_item();
					offer_item(it);
					sent++;
				end
			end
		end
		s_tvalid <= 1'b0;

		while (pending_mix.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_mix.size() == 0) begin
					report_mismatch($sformatf("sample %0d with none expected",
						$signed(m_tdata[19:0])));
				end else begin
					wanted_mix = pending_mix.pop_front();
					if (m_tdata[19:0] !== wanted_mix) begin
						report_mismatch($sformatf("mixed_sample %0d, expected %0d",
							$signed(m_tdata[19:0]), $signed(wanted_mix)));
					end
				end
			end
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left <= HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule
